[rtl/apsp_pkg.sv]
package apsp_pkg;

	typedef logic signed [20:0] dist_t;

	localparam dist_t DIST_INF = 21'sd524288;
	localparam dist_t COST_MAX = 21'sd524287;
	localparam dist_t COST_MIN = -21'sd524288;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_EDGE  = 2'd1,
		OP_RUN   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

endpackage

[rtl/apsp_relax.sv]
module apsp_relax (
	input  apsp_pkg::dist_t dik,
	input  apsp_pkg::dist_t dkj,
	input  apsp_pkg::dist_t dij,
	output logic            upd,
	output apsp_pkg::dist_t sum
);

	logic signed [21:0] raw;

	always_comb begin
		raw = {dik[20], dik} + {dkj[20], dkj};
		if (raw > 22'sd524287) begin
			sum = apsp_pkg::COST_MAX;
		end else if (raw < -22'sd524288) begin
			sum = apsp_pkg::COST_MIN;
		end else begin
			sum = raw[20:0];
		end
		upd = (dik != apsp_pkg::DIST_INF) && (dkj != apsp_pkg::DIST_INF) && (sum < dij);
	end

endmodule

[rtl/apsp_tables.sv]
module apsp_tables #(
	parameter int NODES = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [$clog2(NODES*NODES)-1:0]       waddr,
	input  apsp_pkg::dist_t                      wdist,
	input  logic [$clog2(NODES+1)-1:0]           whop,
	input  logic [$clog2(NODES*NODES)-1:0]       raddr_a,
	input  logic [$clog2(NODES*NODES)-1:0]       raddr_b,
	output apsp_pkg::dist_t                      rdist_a,
	output apsp_pkg::dist_t                      rdist_b,
	output logic [$clog2(NODES+1)-1:0]           rhop_a
);

	localparam int DEPTH = NODES * NODES;
	localparam int HW    = $clog2(NODES + 1);

	apsp_pkg::dist_t dist_mem [DEPTH];
	logic [HW-1:0]   hop_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			dist_mem[waddr] <= wdist;
			hop_mem[waddr]  <= whop;
		end
	end

	always_ff @(posedge clk) begin
		rdist_a <= dist_mem[raddr_a];
		rdist_b <= dist_mem[raddr_b];
		rhop_a  <= hop_mem[raddr_a];
	end

endmodule

[rtl/all_pairs_shortest_path.sv]
// all pairs shortest path engine (floyd-warshall with next-hop tracking)
// input channel: in_valid/in_stall with op, src, dst, edge_cost; a transfer
// happens when in_valid is high and in_stall is low. in_stall is high while
// an item is being worked on, so one item is handled at a time.
// result channel: out_valid/out_stall with path_node, path_cost, no_path, last.
// results sit in an output register; while the receiver stalls the query
// walk waits on that register and nothing is lost.
// config: cfg_valid/cfg_ready writes node_count (cfg_ready is always high).
// steps per item, for N = NODES and n = active node count:
//   load edge: written on the transfer. clear: N*N entries, one table entry per cycle.
//   run closure: for each k, the single relax unit works through the pairs with
//   the table ports (read, then compare and write back, for each pair).
//   query: first result after a table read and check (at once for a self query
//   or out-of-range node); each further node after a test, read and check.
// reset: the tables are swept to unreachable with zero diagonal, and in_stall
// stays high until that pass is done.
module all_pairs_shortest_path #(
	parameter int NODES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic [3:0]         src,
	input  logic [3:0]         dst,
	input  logic signed [15:0] edge_cost,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         path_node,
	output logic signed [19:0] path_cost,
	output logic               no_path,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [4:0]         cfg_data
);

	localparam int NW = $clog2(NODES);
	localparam int AW = $clog2(NODES * NODES);
	localparam int HW = $clog2(NODES + 1);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_CLR   = 12'b000000000010,
		S_RROW  = 12'b000000000100,
		S_RROWD = 12'b000000001000,
		S_RJ    = 12'b000000010000,
		S_RCMP  = 12'b000000100000,
		S_QRD   = 12'b000001000000,
		S_QCHK  = 12'b000010000000,
		S_WTEST = 12'b000100000000,
		S_WRD   = 12'b001000000000,
		S_WCHK  = 12'b010000000000,
		S_EMIT  = 12'b100000000000
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [NW-1:0] r, input logic [NW-1:0] c);
		return AW'(r) * AW'(NODES) + AW'(c);
	endfunction

	state_t state_q, ret_q;
	logic [4:0]    nc_q;
	logic [NW-1:0] i_q, j_q, k_q, s_q, d_q, w_q;
	logic [HW-1:0] cnt_q;
	apsp_pkg::dist_t dik_q, pc_q;
	logic [HW-1:0] hik_q;

	logic [3:0]      em_node_q;
	apsp_pkg::dist_t em_cost_q;
	logic            em_nop_q, em_last_q;

	logic            out_valid_q, no_path_q, last_q;
	logic [3:0]      path_node_q;
	logic [19:0]     path_cost_q;

	logic [HW-1:0]   n_eff;
	logic [NW-1:0]   n_m1;
	logic            in_xfer, load, q_oor, e_in;

	logic            we;
	logic [AW-1:0]   waddr, raddr_a, raddr_b;
	apsp_pkg::dist_t wdist, rdist_a, rdist_b, rsum;
	logic [HW-1:0]   whop, rhop_a;
	logic            rupd;

	always_comb begin
		if (nc_q == 5'd0) begin
			n_eff = HW'(1);
		end else if (7'(nc_q) > 7'(NODES)) begin
			n_eff = HW'(NODES);
		end else begin
			n_eff = HW'(nc_q);
		end
		n_m1 = NW'(n_eff - HW'(1));
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign load      = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign e_in      = (8'(src) < 8'(n_eff)) && (8'(dst) < 8'(n_eff));
	assign q_oor     = !e_in;

	apsp_tables #(.NODES(NODES)) u_tables (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdist   (wdist),
		.whop    (whop),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdist_a (rdist_a),
		.rdist_b (rdist_b),
		.rhop_a  (rhop_a)
	);

	apsp_relax u_relax (
		.dik (dik_q),
		.dkj (rdist_b),
		.dij (rdist_a),
		.upd (rupd),
		.sum (rsum)
	);

	// table write port: edge load, clearing sweep or a relaxation hit
	always_comb begin
		we    = 1'b0;
		waddr = addr_of(i_q, j_q);
		wdist = rsum;
		whop  = hik_q;
		if (state_q == S_CLR) begin
			we    = 1'b1;
			wdist = (i_q == j_q) ? '0 : apsp_pkg::DIST_INF;
			whop  = HW'(NODES);
		end else if (state_q == S_RCMP) begin
			we = rupd;
		end else if (in_xfer && apsp_pkg::op_t'(op) == apsp_pkg::OP_EDGE && e_in) begin
			we    = 1'b1;
			waddr = addr_of(NW'(src), NW'(dst));
			wdist = {{5{edge_cost[15]}}, edge_cost};
			whop  = HW'(dst);
		end
	end

	always_comb begin
		raddr_b = addr_of(k_q, j_q);
		unique case (state_q)
			S_RROW:  raddr_a = addr_of(i_q, k_q);
			S_QRD:   raddr_a = addr_of(s_q, d_q);
			S_WRD:   raddr_a = addr_of(w_q, d_q);
			default: raddr_a = addr_of(i_q, j_q);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= 5'd16;
		end else if (cfg_valid && cfg_ready) begin
			nc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ret_q   <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						s_q <= NW'(src);
						d_q <= NW'(dst);
						unique case (apsp_pkg::op_t'(op))
							apsp_pkg::OP_CLEAR: begin
								i_q     <= '0;
								j_q     <= '0;
								state_q <= S_CLR;
							end
							apsp_pkg::OP_EDGE: state_q <= S_IDLE;
							apsp_pkg::OP_RUN: begin
								i_q     <= '0;
								k_q     <= '0;
								state_q <= S_RROW;
							end
							apsp_pkg::OP_QUERY: begin
								if (q_oor) begin
									em_node_q <= '0;
									em_cost_q <= '0;
									em_nop_q  <= 1'b1;
									em_last_q <= 1'b1;
									ret_q     <= S_IDLE;
									state_q   <= S_EMIT;
								end else if (src == dst) begin
									// self query: the node twice at zero cost
									em_node_q <= src;
									em_cost_q <= '0;
									em_nop_q  <= 1'b0;
									em_last_q <= 1'b0;
									pc_q      <= '0;
									w_q       <= NW'(src);
									cnt_q     <= HW'(NODES);
									ret_q     <= S_WTEST;
									state_q   <= S_EMIT;
								end else begin
									state_q <= S_QRD;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CLR: begin
					if (j_q == NW'(NODES - 1)) begin
						j_q <= '0;
						if (i_q == NW'(NODES - 1)) begin
							state_q <= S_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_RROW: state_q <= S_RROWD;
				S_RROWD: begin
					dik_q <= rdist_a;
					hik_q <= rhop_a;
					if (rdist_a == apsp_pkg::DIST_INF) begin
						if (i_q == n_m1) begin
							if (k_q == n_m1) begin
								state_q <= S_IDLE;
							end else begin
								k_q     <= k_q + 1'b1;
								i_q     <= '0;
								state_q <= S_RROW;
							end
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_RROW;
						end
					end else begin
						j_q     <= '0;
						state_q <= S_RJ;
					end
				end
				S_RJ: state_q <= S_RCMP;
				S_RCMP: begin
					if (j_q != n_m1) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_RJ;
					end else if (i_q != n_m1) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_RROW;
					end else if (k_q != n_m1) begin
						k_q     <= k_q + 1'b1;
						i_q     <= '0;
						state_q <= S_RROW;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_QRD: state_q <= S_QCHK;
				S_QCHK: begin
					pc_q      <= rdist_a;
					em_node_q <= 4'(s_q);
					em_cost_q <= rdist_a;
					em_nop_q  <= 1'b0;
					state_q   <= S_EMIT;
					if (rdist_a == apsp_pkg::DIST_INF || rhop_a >= HW'(NODES)) begin
						em_node_q <= '0;
						em_cost_q <= '0;
						em_nop_q  <= 1'b1;
						em_last_q <= 1'b1;
						ret_q     <= S_IDLE;
					end else if (rhop_a >= n_eff) begin
						em_last_q <= 1'b1;
						ret_q     <= S_IDLE;
					end else begin
						em_last_q <= 1'b0;
						w_q       <= NW'(rhop_a);
						cnt_q     <= HW'(2);
						ret_q     <= S_WTEST;
					end
				end
				S_WTEST: begin
					if (w_q == d_q || cnt_q == HW'(NODES)) begin
						em_node_q <= 4'(w_q);
						em_cost_q <= pc_q;
						em_nop_q  <= 1'b0;
						em_last_q <= 1'b1;
						ret_q     <= S_IDLE;
						state_q   <= S_EMIT;
					end else begin
						state_q <= S_WRD;
					end
				end
				S_WRD: state_q <= S_WCHK;
				S_WCHK: begin
					em_node_q <= 4'(w_q);
					em_cost_q <= pc_q;
					em_nop_q  <= 1'b0;
					state_q   <= S_EMIT;
					if (rhop_a >= n_eff) begin
						em_last_q <= 1'b1;
						ret_q     <= S_IDLE;
					end else begin
						em_last_q <= 1'b0;
						w_q       <= NW'(rhop_a);
						cnt_q     <= cnt_q + 1'b1;
						ret_q     <= S_WTEST;
					end
				end
				S_EMIT: begin
					if (load) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			path_node_q <= em_node_q;
			path_cost_q <= em_cost_q[19:0];
			no_path_q   <= em_nop_q;
			last_q      <= em_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign path_cost = path_cost_q;
	assign no_path   = no_path_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && em_last_q) |=> (state_q == S_IDLE))
		else $error("final result did not end the query");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WCHK) |-> (cnt_q < HW'(NODES)))
		else $error("path walk ran past the node limit");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_IDLE || state_q == S_CLR || state_q == S_RCMP))
		else $error("table written outside load, clear or relax");
`endif

endmodule

[tb/sv/all_pairs_shortest_path_test.sv]
module all_pairs_shortest_path_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 16;
	localparam int HOP_NONE = NODES;
	localparam int LIMIT = 4000000;

	typedef struct packed {
		logic [3:0]         node;
		logic signed [19:0] cost;
		logic               miss;
		logic               fin;
	} hop_rec_t;

	typedef struct {
		apsp_pkg::op_t code;
		logic [3:0]    s;
		logic [3:0]    d;
		logic [15:0]   w;
		bit            typed;
		hop_rec_t      want;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] op = '0;
	logic [3:0] src = '0;
	logic [3:0] dst = '0;
	logic signed [15:0] edge_cost = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [3:0] path_node;
	logic signed [19:0] path_cost;
	logic no_path;
	logic last;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;

	all_pairs_shortest_path #(.NODES(NODES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .src(src), .dst(dst), .edge_cost(edge_cost),
		.out_valid(out_valid), .out_stall(out_stall),
		.path_node(path_node), .path_cost(path_cost), .no_path(no_path), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	apsp_pkg::dist_t dist_mx [NODES][NODES];
	int       hop_mx  [NODES][NODES];
	int       node_cfg = 16;
	hop_rec_t path_q [$];
	int       errors = 0;
	int       cycles = 0;
	bit       hold_off = 0;

	function automatic int nodes_used();
		if (node_cfg == 0) return 1;
		if (node_cfg > NODES) return NODES;
		return node_cfg;
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < NODES; i++)
			for (int j = 0; j < NODES; j++) begin
				dist_mx[i][j] = (i == j) ? '0 : apsp_pkg::DIST_INF;
				hop_mx[i][j] = HOP_NONE;
			end
	endfunction

	function automatic void close_graph();
		int n;
		apsp_pkg::dist_t s;
		n = nodes_used();
		for (int k = 0; k < n; k++)
			for (int i = 0; i < n; i++) begin
				if (dist_mx[i][k] == apsp_pkg::DIST_INF) continue;
				for (int j = 0; j < n; j++) begin
					if (dist_mx[k][j] == apsp_pkg::DIST_INF) continue;
					s = dist_mx[i][k] + dist_mx[k][j];
					if (s > apsp_pkg::COST_MAX) s = apsp_pkg::COST_MAX;
					else if (s < apsp_pkg::COST_MIN) s = apsp_pkg::COST_MIN;
					if (s < dist_mx[i][j]) begin
						dist_mx[i][j] = s;
						hop_mx[i][j] = hop_mx[i][k];
					end
				end
			end
	endfunction

	// updates the graph and queues the path records one item produces
	function automatic int apply_item(apsp_pkg::op_t code, int s, int d,
			logic signed [15:0] w);
		int n, cnt, at, nh;
		apsp_pkg::dist_t pc;
		n = nodes_used();
		case (code)
			apsp_pkg::OP_CLEAR: wipe_graph();
			apsp_pkg::OP_EDGE: if (s < n && d < n) begin
				dist_mx[s][d] = w;
				hop_mx[s][d] = d;
			end
			apsp_pkg::OP_RUN: close_graph();
			apsp_pkg::OP_QUERY: begin
				if (s >= n || d >= n) begin
					path_q.push_back('{4'd0, 20'sd0, 1'b1, 1'b1});
					return 1;
				end
				if (s == d) begin
					path_q.push_back('{4'(s), 20'sd0, 1'b0, 1'b0});
					path_q.push_back('{4'(d), 20'sd0, 1'b0, 1'b1});
					return 2;
				end
				pc = dist_mx[s][d];
				if (pc == apsp_pkg::DIST_INF || hop_mx[s][d] >= HOP_NONE) begin
					path_q.push_back('{4'd0, 20'sd0, 1'b1, 1'b1});
					return 1;
				end
				path_q.push_back('{4'(s), pc[19:0], 1'b0, 1'b0});
				at = s;
				cnt = 1;
				while (at != d && cnt < NODES) begin
					nh = hop_mx[at][d];
					if (nh >= n) break;
					at = nh;
					path_q.push_back('{4'(at), pc[19:0], 1'b0, 1'b0});
					cnt++;
				end
				path_q[$].fin = 1;
				return cnt;
			end
		endcase
		return 0;
	endfunction

	task automatic send_item(apsp_pkg::op_t code, int s, int d, logic [15:0] w);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1;
		op <= code;
		src <= 4'(s);
		dst <= 4'(d);
		edge_cost <= w;
		do @(posedge clk); while (in_stall);
		in_valid <= 0;
		void'(apply_item(code, s, d, w));
		@(posedge clk);
	endtask

	task automatic drain();
		while (path_q.size() != 0 && cycles < LIMIT) @(posedge clk);
		// an idle item may still be running (clear or closure)
		repeat (2 * NODES * NODES * NODES + 4 * NODES * NODES) @(posedge clk);
	endtask

	task automatic write_count(int v);
		cfg_valid <= 1;
		cfg_data <= 5'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		node_cfg = v;
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall pattern, with one long hold-off on request
	always @(posedge clk) begin
		if (hold_off) out_stall <= 1;
		else out_stall <= ((cycles % 37) < 9) ? ($urandom_range(0, 1) == 1) : 1'b0;
	end

	always @(posedge clk) begin
		hop_rec_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (path_q.size() == 0) begin
				$display("%0t: unexpected result node %0d cost %0d", $time, path_node, path_cost);
				errors++;
			end else begin
				e = path_q.pop_front();
				if (e.node !== path_node || e.cost !== path_cost
						|| e.miss !== no_path || e.fin !== last) begin
					$display("%0t: expected node %0d cost %0d no_path %0b last %0b,",
						$time, e.node, e.cost, e.miss, e.fin);
					$display("%0t:   actual node %0d cost %0d no_path %0b last %0b",
						$time, path_node, path_cost, no_path, last);
					errors++;
				end
			end
		end
	end

	stim_row_t rows [] = '{
		'{apsp_pkg::OP_QUERY, 0, 0, 16'h0, 1, '{0, 0, 0, 1}},
		'{apsp_pkg::OP_QUERY, 0, 15, 16'h0, 1, '{0, 0, 1, 1}},
		'{apsp_pkg::OP_EDGE, 0, 1, 16'h7fff, 0, '0},
		'{apsp_pkg::OP_EDGE, 1, 2, 16'h7fff, 0, '0},
		'{apsp_pkg::OP_EDGE, 2, 3, 16'h8000, 0, '0},
		'{apsp_pkg::OP_EDGE, 3, 15, 16'h0005, 0, '0},
		'{apsp_pkg::OP_EDGE, 0, 1, 16'h0003, 0, '0},
		'{apsp_pkg::OP_EDGE, 4, 4, 16'h0002, 0, '0},
		'{apsp_pkg::OP_EDGE, 15, 14, 16'hffff, 0, '0},
		'{apsp_pkg::OP_RUN, 0, 0, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 0, 15, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 15, 14, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 15, 15, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 4, 4, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 14, 0, 16'h0, 1, '{0, 0, 1, 1}},
		'{apsp_pkg::OP_CLEAR, 0, 0, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 0, 15, 16'h0, 1, '{0, 0, 1, 1}},
		'{apsp_pkg::OP_EDGE, 5, 6, 16'h8000, 0, '0},
		'{apsp_pkg::OP_EDGE, 6, 5, 16'h8000, 0, '0},
		'{apsp_pkg::OP_RUN, 0, 0, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 5, 6, 16'h0, 0, '0},
		'{apsp_pkg::OP_QUERY, 6, 5, 16'h0, 0, '0}
	};

	task automatic random_graph(int n, int edges);
		int a, b;
		send_item(apsp_pkg::OP_CLEAR, 0, 0, $urandom);
		for (int e = 0; e < edges; e++) begin
			// mostly in range, sometimes beyond the node count
			a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
			b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
			if ($urandom_range(0, 7) == 0) send_item(apsp_pkg::OP_EDGE, a, b, $urandom);
			else send_item(apsp_pkg::OP_EDGE, a, b, $urandom_range(0, 40));
		end
		send_item(apsp_pkg::OP_RUN, $urandom, $urandom, $urandom);
		for (int q = 0; q < 6; q++)
			send_item(apsp_pkg::OP_QUERY, $urandom_range(0, n), $urandom_range(0, n), $urandom);
	endtask

	initial begin
		int sent;
		hop_rec_t got;
		wipe_graph();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[r]) begin
			send_item(rows[r].code, rows[r].s, rows[r].d, rows[r].w);
			if (rows[r].typed) begin
				got = path_q[$];
				if (path_q.size() != 0 && rows[r].want != got
						&& rows[r].code == apsp_pkg::OP_QUERY) begin
					$display("%0t: table row %0d expected %p, predicted %p", $time, r,
						rows[r].want, got);
					errors++;
				end
			end
		end

		// fill the block while the receiver holds off
		hold_off = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			for (int q = 0; q < 4; q++)
				send_item(apsp_pkg::OP_QUERY, 0, $urandom_range(0, 15), 0);
		join
		drain();

		sent = 0;
		for (int ph = 0; sent < 120; ph++) begin
			int nc;
			case (ph % 5)
				0: nc = 1;
				1: nc = 16;
				2: nc = 0;
				3: nc = $urandom_range(17, 31);
				default: nc = $urandom_range(2, 15);
			endcase
			write_count(nc);
			random_graph(nodes_used(), 12);
			sent += 20;
			drain();
		end

		if (errors == 0 && path_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
